### rtl/serial_command_line_parser_macros.svh
// Assertion macros shared by the parser RTL.
// Each macro samples on clk and is disabled while rst_n is low.
`ifndef SERIAL_COMMAND_LINE_PARSER_MACROS_SVH
`define SERIAL_COMMAND_LINE_PARSER_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define SCLP_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define SCLP_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/scl_pkg.sv
package scl_pkg;

    localparam int LINE_BUFFER_SIZE_DEF = 16;

    // Only the first few characters of a line can ever match a command word.
    localparam int SLOTS      = 5;
    localparam int SLOT_IDX_W = $clog2(SLOTS);

    localparam logic [7:0] CHAR_BS    = 8'd8;
    localparam logic [7:0] CHAR_LF    = 8'd10;
    localparam logic [7:0] CHAR_CR    = 8'd13;
    localparam logic [7:0] CHAR_SPACE = 8'd32;
    localparam logic [7:0] CHAR_TILDE = 8'd126;
    localparam logic [7:0] CHAR_DEL   = 8'd127;
    localparam logic [7:0] CHAR_LOW_A = 8'd97;
    localparam logic [7:0] CHAR_LOW_Z = 8'd122;
    localparam logic [7:0] CASE_DIFF  = 8'd32;

    localparam logic [31:0] WORD_DATA  = "DATA";
    localparam logic [39:0] WORD_CLEAN = "CLEAN";
    localparam logic [31:0] WORD_INFO  = "INFO";
    localparam logic [31:0] WORD_HELP  = "HELP";
    localparam int          LEN_SHORT  = 4;
    localparam int          LEN_CLEAN  = 5;

    typedef enum logic [1:0] {
        ACT_NONE,
        ACT_ECHO,
        ACT_ERASE,
        ACT_DONE
    } scl_action_t;

    typedef enum logic [2:0] {
        CMD_DATA,
        CMD_CLEAN,
        CMD_INFO,
        CMD_HELP,
        CMD_UNKNOWN
    } scl_cmd_t;

    typedef logic [SLOTS-1:0][7:0] scl_slots_t;

    typedef struct packed {
        scl_action_t action;
        logic [7:0]  echo_char;
        scl_cmd_t    command_code;
    } scl_result_t;

    function automatic logic [7:0] to_upper(input logic [7:0] c);
        logic [7:0] r;
        r = c;
        if (c >= CHAR_LOW_A && c <= CHAR_LOW_Z)
        begin
            r = c - CASE_DIFF;
        end
        return r;
    endfunction

endpackage

### rtl/scl_cmd_match.sv
module scl_cmd_match #(
    parameter int LEN_W = 4
) (
    input  scl_pkg::scl_slots_t slots,
    input  logic [LEN_W-1:0]    line_length,
    output scl_pkg::scl_cmd_t   command_code
);

    logic [31:0] head4;
    logic [39:0] head5;
    logic        len_short;
    logic        len_clean;

    assign head4     = {slots[0], slots[1], slots[2], slots[3]};
    assign head5     = {slots[0], slots[1], slots[2], slots[3], slots[4]};
    assign len_short = (line_length == LEN_W'(scl_pkg::LEN_SHORT));
    assign len_clean = (line_length == LEN_W'(scl_pkg::LEN_CLEAN));

    always_comb
    begin
        if (len_short && head4 == scl_pkg::WORD_DATA)
        begin
            command_code = scl_pkg::CMD_DATA;
        end
        else if (len_clean && head5 == scl_pkg::WORD_CLEAN)
        begin
            command_code = scl_pkg::CMD_CLEAN;
        end
        else if (len_short && head4 == scl_pkg::WORD_INFO)
        begin
            command_code = scl_pkg::CMD_INFO;
        end
        else if (len_short && head4 == scl_pkg::WORD_HELP)
        begin
            command_code = scl_pkg::CMD_HELP;
        end
        else
        begin
            command_code = scl_pkg::CMD_UNKNOWN;
        end
    end

endmodule

### rtl/scl_line_editor.sv
`include "serial_command_line_parser_macros.svh"

module scl_line_editor #(
    parameter int LINE_BUFFER_SIZE = scl_pkg::LINE_BUFFER_SIZE_DEF
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                step,
    input  logic [7:0]          rx_byte,
    output scl_pkg::scl_result_t result
);

    localparam int              LEN_W   = $clog2(LINE_BUFFER_SIZE);
    localparam logic [LEN_W-1:0] LEN_CAP = LEN_W'(LINE_BUFFER_SIZE - 1);

    logic [LEN_W-1:0]    line_length_reg;
    logic [LEN_W-1:0]    line_length_next;
    scl_pkg::scl_slots_t slot_reg;
    logic [7:0]          c_up;
    logic                store_wr;
    scl_pkg::scl_cmd_t   match_code;

    scl_cmd_match #(
        .LEN_W (LEN_W)
    ) u_match (
        .slots        (slot_reg),
        .line_length  (line_length_reg),
        .command_code (match_code)
    );

    assign c_up = scl_pkg::to_upper(rx_byte);

    always_comb
    begin
        result           = '0;
        line_length_next = line_length_reg;
        store_wr         = 1'b0;
        if (c_up inside {scl_pkg::CHAR_CR, scl_pkg::CHAR_LF})
        begin
            if (line_length_reg != '0)
            begin
                result.action       = scl_pkg::ACT_DONE;
                result.command_code = match_code;
                line_length_next    = '0;
            end
        end
        else if (c_up inside {[scl_pkg::CHAR_SPACE:scl_pkg::CHAR_TILDE]})
        begin
            if (line_length_reg < LEN_CAP)
            begin
                result.action    = scl_pkg::ACT_ECHO;
                result.echo_char = c_up;
                line_length_next = line_length_reg + 1'b1;
                store_wr         = 1'b1;
            end
        end
        else if (c_up inside {scl_pkg::CHAR_DEL, scl_pkg::CHAR_BS})
        begin
            if (line_length_reg != '0)
            begin
                result.action    = scl_pkg::ACT_ERASE;
                line_length_next = line_length_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            line_length_reg <= '0;
        end
        else if (step)
        begin
            line_length_reg <= line_length_next;
        end
    end

    // Characters past the longest command word are counted but not kept.
    always_ff @(posedge clk)
    begin
        for (int i = 0; i < scl_pkg::SLOTS; i++)
        begin
            if (step && store_wr && line_length_reg == LEN_W'(i))
            begin
                slot_reg[i] <= c_up;
            end
        end
    end

    `SCLP_ASSERT_IMP(a_len_cap, 1'b1, line_length_reg <= LEN_CAP, "Line length exceeds capacity.")
    `SCLP_ASSERT_NXT(a_done_clears, step && result.action == scl_pkg::ACT_DONE, line_length_reg == '0, "Completed command did not empty the line.")
    `SCLP_ASSERT_NXT(a_erase_dec, step && result.action == scl_pkg::ACT_ERASE, line_length_reg == $past(line_length_reg) - 1'b1, "Erase did not shorten the line by one.")

endmodule

### rtl/serial_command_line_parser.sv
// A byte taken on the input is held in in_byte_reg; its result is then registered
// in out_result_reg. Throughput: one byte per cycle unless m_tready holds the output;
// the line state updates in the same cycle as the result, so bytes follow without gaps.
// Reset (rst_n, asynchronous, active low) empties the line and both stages.
`include "serial_command_line_parser_macros.svh"

module serial_command_line_parser #(
    parameter int LINE_BUFFER_SIZE = scl_pkg::LINE_BUFFER_SIZE_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [7:0] echo_char, [10:8] command_code, rest zero
    output logic [1:0]  m_tuser    // [1:0] action
);

    logic                 in_valid_reg;
    logic [7:0]           in_byte_reg;
    logic                 out_valid_reg;
    scl_pkg::scl_result_t out_result_reg;
    scl_pkg::scl_result_t result_next;
    logic                 advance;

    assign advance  = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || advance;

    scl_line_editor #(
        .LINE_BUFFER_SIZE (LINE_BUFFER_SIZE)
    ) u_editor (
        .clk     (clk),
        .rst_n   (rst_n),
        .step    (advance),
        .rx_byte (in_byte_reg),
        .result  (result_next)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (s_tready)
            begin
                in_valid_reg <= s_tvalid;
            end
            if (advance)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
        begin
            in_byte_reg <= s_tdata;
        end
        if (advance)
        begin
            out_result_reg <= result_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tuser  = out_result_reg.action;
    assign m_tdata  = {5'b0, out_result_reg.command_code, out_result_reg.echo_char};

    `SCLP_ASSERT_IMP(a_echo_printable, m_tvalid && out_result_reg.action == scl_pkg::ACT_ECHO, out_result_reg.echo_char >= scl_pkg::CHAR_SPACE && out_result_reg.echo_char <= scl_pkg::CHAR_TILDE && !(out_result_reg.echo_char >= scl_pkg::CHAR_LOW_A && out_result_reg.echo_char <= scl_pkg::CHAR_LOW_Z), "Echoed character is not an uppercased printable byte.")
    `SCLP_ASSERT_IMP(a_echo_zero, m_tvalid && out_result_reg.action != scl_pkg::ACT_ECHO, out_result_reg.echo_char == 8'd0, "Echo character set without an echo.")
    `SCLP_ASSERT_IMP(a_code_zero, m_tvalid && out_result_reg.action != scl_pkg::ACT_DONE, out_result_reg.command_code == scl_pkg::CMD_DATA, "Command code set without a completed command.")

endmodule
